// ===== rtl/dwtr_pkg.sv =====
`timescale 1ns / 1ps

package dwtr_pkg;

  localparam int unsigned MAX_CHANNELS = 4096;
  localparam int unsigned MAX_KERNEL   = 8;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ADDR_W   = 30;
  localparam int unsigned CFG_CH_W = 13;
  localparam int unsigned CFG_K_W  = 4;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CH_W     = 12;
  localparam int unsigned K_W      = 3;
  localparam int unsigned TILE_W   = 5;
  localparam int unsigned BLK_W    = CH_W - TILE_W;
  localparam int unsigned ICB_W    = 8;
  localparam int unsigned KHW_W    = 7;
  localparam int unsigned KP_W     = 14;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned KK_W     = 13;
  localparam int unsigned TADDR_W  = ADDR_W - 10;

  typedef enum logic [IDX_W-1:0] {
    REG_IN_CHANNELS   = 8'd0,
    REG_OUT_CHANNELS  = 8'd1,
    REG_KERNEL_WIDTH  = 8'd2,
    REG_KERNEL_HEIGHT = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [WORD_W-1:0] weight_out;
    logic              last_word;
  } result_t;

  typedef struct packed {
    logic load_in;
    logic do_pos;
    logic do_mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [CFG_CH_W-1:0] clamp_ch(input logic [CFG_CH_W-1:0] v);
    logic [CFG_CH_W-1:0] r;
    if (v == '0) begin
      r = CFG_CH_W'(1);
    end else if (v > CFG_CH_W'(MAX_CHANNELS)) begin
      r = CFG_CH_W'(MAX_CHANNELS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CFG_K_W-1:0] clamp_k(input logic [CFG_K_W-1:0] v);
    logic [CFG_K_W-1:0] r;
    if (v == '0) begin
      r = CFG_K_W'(1);
    end else if (v > CFG_K_W'(MAX_KERNEL)) begin
      r = CFG_K_W'(MAX_KERNEL);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/dwtr_if.sv =====
`timescale 1ns / 1ps

interface dwtr_in_if;
  import dwtr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] weight_in;
  modport source (output valid, output weight_in, input ready);
  modport sink   (input valid, input weight_in, output ready);
endinterface

interface dwtr_out_if;
  import dwtr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [WORD_W-1:0] weight_out;
  logic              last_word;
  modport source (output valid, output dest_address, output weight_out, output last_word,
                  input ready);
  modport sink   (input valid, input dest_address, input weight_out, input last_word,
                  output ready);
endinterface

interface dwtr_cfg_if;
  import dwtr_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dwtr_ctrl.sv =====
`timescale 1ns / 1ps

module dwtr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dwtr_pkg::status_t status_i,
  output dwtr_pkg::cmd_t    cmd_o
);
  import dwtr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_POS    = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_POS;
        end
      end
      ST_POS: begin
        cmd_o.do_pos = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.do_mul = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold the finished address until the output register has room.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dwtr_dpath.sv =====
`timescale 1ns / 1ps

module dwtr_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dwtr_pkg::cmd_t              cmd_i,
  output dwtr_pkg::status_t           status_o,
  input  logic [dwtr_pkg::WORD_W-1:0] weight_i,
  input  logic                        cfg_valid_i,
  input  logic [dwtr_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [dwtr_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dwtr_pkg::result_t           result_o
);
  import dwtr_pkg::*;

  // Configuration registers.
  logic [CFG_CH_W-1:0] in_ch_q, out_ch_q;
  logic [CFG_K_W-1:0]  kw_cfg_q, kh_cfg_q;
  logic                cfg_hit;

  // Derived layout constants, refreshed every cycle from the registers.
  logic [ICB_W-1:0] icb_q, icb_d;
  logic [KHW_W-1:0] khw_q, khw_d;
  logic [KP_W-1:0]  kp_q, kp_d;

  // Position counters.
  logic [CH_W-1:0] i_cnt_q, o_cnt_q;
  logic [K_W-1:0]  r_cnt_q, c_cnt_q;

  // Per-word working registers.
  logic [WORD_W-1:0]  word_q;
  logic [CH_W-1:0]    i_q, o_q;
  logic [K_W-1:0]     fr_q, fc_q;
  logic               last_q;
  logic [POS_W-1:0]   pos_q;
  logic [KK_W-1:0]    kk_q;
  logic [TADDR_W-1:0] obkp_q;

  logic              out_valid_q;
  result_t           result_q;

  logic [CFG_CH_W-1:0] ic, oc;
  logic [CFG_K_W-1:0]  kw, kh;
  logic                c_wrap, r_wrap, o_wrap, i_wrap;
  logic                last_d;

  assign ic = clamp_ch(in_ch_q);
  assign oc = clamp_ch(out_ch_q);
  assign kw = clamp_k(kw_cfg_q);
  assign kh = clamp_k(kh_cfg_q);

  assign cfg_hit = cfg_valid_i && (cfg_index_i == REG_IN_CHANNELS ||
                                   cfg_index_i == REG_OUT_CHANNELS ||
                                   cfg_index_i == REG_KERNEL_WIDTH ||
                                   cfg_index_i == REG_KERNEL_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= CFG_CH_W'(32);
      out_ch_q <= CFG_CH_W'(32);
      kw_cfg_q <= CFG_K_W'(3);
      kh_cfg_q <= CFG_K_W'(3);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IN_CHANNELS:   in_ch_q  <= cfg_data_i[CFG_CH_W-1:0];
        REG_OUT_CHANNELS:  out_ch_q <= cfg_data_i[CFG_CH_W-1:0];
        REG_KERNEL_WIDTH:  kw_cfg_q <= cfg_data_i[CFG_K_W-1:0];
        REG_KERNEL_HEIGHT: kh_cfg_q <= cfg_data_i[CFG_K_W-1:0];
        default: ;
      endcase
    end
  end

  assign icb_d = ICB_W'(((CFG_CH_W + 1)'(ic) + (CFG_CH_W + 1)'(31)) >> TILE_W);
  assign khw_d = KHW_W'(KHW_W'(kh) * KHW_W'(kw));
  assign kp_d  = KP_W'(KP_W'(khw_q) * KP_W'(icb_q));

  always_ff @(posedge clk_i) begin
    icb_q <= icb_d;
    khw_q <= khw_d;
    kp_q  <= kp_d;
  end

  // Counter advance: column innermost, input channel outermost.
  assign c_wrap = (CFG_K_W'(c_cnt_q) + CFG_K_W'(1)) >= kw;
  assign r_wrap = (CFG_K_W'(r_cnt_q) + CFG_K_W'(1)) >= kh;
  assign o_wrap = (CFG_CH_W'(o_cnt_q) + CFG_CH_W'(1)) >= oc;
  assign i_wrap = (CFG_CH_W'(i_cnt_q) + CFG_CH_W'(1)) >= ic;

  assign last_d = (i_cnt_q == CH_W'(ic - CFG_CH_W'(1))) &&
                  (o_cnt_q == CH_W'(oc - CFG_CH_W'(1))) &&
                  (r_cnt_q == K_W'(kh - CFG_K_W'(1))) &&
                  (c_cnt_q == K_W'(kw - CFG_K_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_cnt_q <= '0;
      o_cnt_q <= '0;
      r_cnt_q <= '0;
      c_cnt_q <= '0;
    end else if (cfg_hit) begin
      i_cnt_q <= '0;
      o_cnt_q <= '0;
      r_cnt_q <= '0;
      c_cnt_q <= '0;
    end else if (cmd_i.load_in) begin
      if (!c_wrap) begin
        c_cnt_q <= c_cnt_q + K_W'(1);
      end else begin
        c_cnt_q <= '0;
        if (!r_wrap) begin
          r_cnt_q <= r_cnt_q + K_W'(1);
        end else begin
          r_cnt_q <= '0;
          if (!o_wrap) begin
            o_cnt_q <= o_cnt_q + CH_W'(1);
          end else begin
            o_cnt_q <= '0;
            if (!i_wrap) begin
              i_cnt_q <= i_cnt_q + CH_W'(1);
            end else begin
              i_cnt_q <= '0;
            end
          end
        end
      end
    end
  end

  // Address pipeline: flipped kernel position, then the two products, then the sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      word_q <= weight_i;
      i_q    <= i_cnt_q;
      o_q    <= o_cnt_q;
      fr_q   <= K_W'(kh - CFG_K_W'(1)) - r_cnt_q;
      fc_q   <= K_W'(kw - CFG_K_W'(1)) - c_cnt_q;
      last_q <= last_d;
    end
    if (cmd_i.do_pos) begin
      pos_q <= POS_W'(KHW_W'(fr_q) * KHW_W'(kw) + KHW_W'(fc_q));
    end
    if (cmd_i.do_mul) begin
      kk_q   <= KK_W'(KP_W'(pos_q) * KP_W'(icb_q) + KP_W'(i_q[CH_W-1:TILE_W]));
      obkp_q <= TADDR_W'((KP_W + BLK_W)'(o_q[CH_W-1:TILE_W]) * (KP_W + BLK_W)'(kp_q));
    end
    if (cmd_i.load_out) begin
      result_q.dest_address <= {obkp_q + TADDR_W'(kk_q), i_q[TILE_W-1:1],
                                o_q[TILE_W-1:0], i_q[0]};
      result_q.weight_out   <= word_q;
      result_q.last_word    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign result_o          = result_q;

endmodule

// ===== rtl/deconv_weight_tiled_reorder_core.sv =====
`timescale 1ns / 1ps

// Weight flip and tiled reorder for transposed-convolution weights.
// req_i carries one 16-bit weight per request, in source order: input channel
// outermost, then output channel, kernel row, kernel column. rsp_o returns one
// result per request: the destination element index in the 32x32 tiled layout
// (kernel flipped, input-channel pairs interleaved), the weight unchanged and a
// flag on the final weight of the tensor.
// cfg_i writes in_channels, out_channels, kernel_width and kernel_height
// (indexes 0 to 3) and is always ready; any such write restarts the tensor at
// the next weight. Writes to other indexes are dropped. Write only while idle.
// For each request the controller walks the position, multiply and sum steps of the
// address path, and it takes no new request until the sum is in the output register.
// The result sits in an output register, so a request may be taken while the
// previous result still waits; when the receiver stalls longer, the finished
// address waits in the datapath and req_i.ready stays low.
// Reset loads 32 channels each way and a 3x3 kernel and clears the position
// counters; the block is ready for a request right after reset.
module deconv_weight_tiled_reorder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwtr_in_if.sink    req_i,
  dwtr_out_if.source rsp_o,
  dwtr_cfg_if.sink   cfg_i
);
  import dwtr_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  dwtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dwtr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .weight_i    (req_i.weight_in),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .result_o    (result)
  );

  assign cfg_i.ready        = 1'b1;
  assign rsp_o.dest_address = result.dest_address;
  assign rsp_o.weight_out   = result.weight_out;
  assign rsp_o.last_word    = result.last_word;

endmodule

// ===== test/deconv_weight_tiled_reorder_core_tb.sv =====
`timescale 1ns / 1ps

module deconv_weight_tiled_reorder_core_tb;
  import dwtr_pkg::*;

  localparam int unsigned WORD_COUNT     = 2000;
  localparam int unsigned CYCLE_LIMIT    = 2000000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned MAX_PAUSE      = 10;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned TILE           = 32;
  localparam int unsigned TILE_AREA      = 1024;
  localparam int unsigned PAIR_STRIDE    = 64;
  localparam int unsigned RESET_CHANNELS = 32;
  localparam int unsigned RESET_KERNEL   = 3;
  localparam int unsigned NUM_REGS       = int'(REG_KERNEL_HEIGHT) + 1;
  localparam int unsigned FIRST_UNUSED_IDX = NUM_REGS;
  localparam int unsigned IDX_TOP        = (1 << IDX_W) - 1;

  typedef longint unsigned wide_t;

  typedef struct {
    bit                is_reg;
    logic [IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]  reg_data;
    logic [WORD_W-1:0] word;
  } feed_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dwtr_in_if  req_if ();
  dwtr_out_if rsp_if ();
  dwtr_cfg_if cfg_if ();

  deconv_weight_tiled_reorder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the layer registers and the source-order position.
  logic [CFG_CH_W-1:0] layer_in_ch;
  logic [CFG_CH_W-1:0] layer_out_ch;
  logic [CFG_K_W-1:0]  layer_kw;
  logic [CFG_K_W-1:0]  layer_kh;
  int unsigned in_pos, out_pos, row_pos, col_pos;

  result_t placement_q[$];
  feed_t   word_feed[$];

  int unsigned words_sent     = 0;
  int unsigned reg_writes     = 0;
  int unsigned ignored_writes = 0;
  int unsigned shapes         = 0;
  int unsigned tensors_done   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_cnt      = 0;

  int unsigned feed_gap;
  int unsigned settle;
  int unsigned sink_hold;
  bit          feed_calm;
  bit          sink_calm;
  logic        next_req_valid;
  logic        next_cfg_valid;
  result_t     want;

  function automatic int unsigned limit_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Flips the kernel position of the next source word and places it in the tiled layout.
  function automatic result_t place_word(input logic [WORD_W-1:0] w);
    int unsigned ic, oc, kw, kh, i, o, r, c, fr, fc, icb, ix;
    wide_t   kp, kk, addr;
    result_t res;
    ic = limit_dim(32'(layer_in_ch), MAX_CHANNELS);
    oc = limit_dim(32'(layer_out_ch), MAX_CHANNELS);
    kw = limit_dim(32'(layer_kw), MAX_KERNEL);
    kh = limit_dim(32'(layer_kh), MAX_KERNEL);
    i = (in_pos < ic) ? in_pos : 0;
    o = (out_pos < oc) ? out_pos : 0;
    r = (row_pos < kh) ? row_pos : 0;
    c = (col_pos < kw) ? col_pos : 0;
    fr = kh - 1 - r;
    fc = kw - 1 - c;
    icb = (ic + TILE - 1) / TILE;
    kp = wide_t'(kh) * kw * icb;
    kk = (wide_t'(fr) * kw + fc) * icb + i / TILE;
    ix = i % TILE;
    addr = (wide_t'(o / TILE) * kp + kk) * TILE_AREA + wide_t'(ix >> 1) * PAIR_STRIDE
           + wide_t'(o % TILE) * 2 + (ix & 1);
    res.dest_address = addr[ADDR_W-1:0];
    res.weight_out   = w;
    res.last_word    = (i == ic - 1) && (o == oc - 1) && (r == kh - 1) && (c == kw - 1);
    c++;
    if (c >= kw) begin
      c = 0;
      r++;
      if (r >= kh) begin
        r = 0;
        o++;
        if (o >= oc) begin
          o = 0;
          i++;
          if (i >= ic) i = 0;
        end
      end
    end
    in_pos  = i;
    out_pos = o;
    row_pos = r;
    col_pos = c;
    return res;
  endfunction

  // Any write to a real register starts a new tensor; other indexes are dropped.
  function automatic void write_layer_reg(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    case (idx)
      REG_IN_CHANNELS:   layer_in_ch  = data[CFG_CH_W-1:0];
      REG_OUT_CHANNELS:  layer_out_ch = data[CFG_CH_W-1:0];
      REG_KERNEL_WIDTH:  layer_kw     = data[CFG_K_W-1:0];
      REG_KERNEL_HEIGHT: layer_kh     = data[CFG_K_W-1:0];
      default: begin
        ignored_writes++;
        return;
      end
    endcase
    in_pos  = 0;
    out_pos = 0;
    row_pos = 0;
    col_pos = 0;
    reg_writes++;
  endfunction

  // Each side switches now and then between back-to-back and random pauses.
  function automatic int unsigned pause_len(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return WORD_W'($urandom_range(0, (1 << WORD_W) - 1));
  endfunction

  // Mostly small channel counts so that whole tensors complete and wrap.
  function automatic logic [CFG_W-1:0] pick_channels();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return CFG_W'($urandom_range(0, 6));
    if (roll < 9) return CFG_W'($urandom_range(7, 70));
    return $urandom_range(0, 1) ? CFG_W'(MAX_CHANNELS)
                                : CFG_W'($urandom_range(71, (1 << CFG_W) - 1));
  endfunction

  // Upper data bits are random; only the low kernel bits are kept by the block.
  function automatic logic [CFG_W-1:0] pick_kernel();
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    v[CFG_K_W-1:0] = CFG_K_W'(($urandom_range(0, 3) == 0)
                              ? $urandom_range(0, (1 << CFG_K_W) - 1)
                              : $urandom_range(0, 3));
    return v;
  endfunction

  task automatic queue_word(input logic [WORD_W-1:0] w);
    feed_t f;
    f.is_reg   = 1'b0;
    f.reg_idx  = '0;
    f.reg_data = '0;
    f.word     = w;
    word_feed.push_back(f);
  endtask

  task automatic queue_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    feed_t f;
    f.is_reg   = 1'b1;
    f.reg_idx  = idx;
    f.reg_data = data;
    f.word     = '0;
    word_feed.push_back(f);
  endtask

  task automatic set_layer(input logic [CFG_W-1:0] ic, input logic [CFG_W-1:0] oc,
                           input logic [CFG_W-1:0] kw, input logic [CFG_W-1:0] kh);
    queue_reg(REG_IN_CHANNELS, ic);
    queue_reg(REG_OUT_CHANNELS, oc);
    queue_reg(REG_KERNEL_WIDTH, kw);
    queue_reg(REG_KERNEL_HEIGHT, kh);
    shapes++;
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // Request driver: weights and register writes in feed order. A register write
  // waits until every placement has come back and the datapath has settled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.weight_in <= '0;
      cfg_if.valid     <= 1'b0;
      cfg_if.index     <= '0;
      cfg_if.data      <= '0;
      feed_gap     = 0;
      settle       = 0;
      feed_calm    = 1'b0;
      layer_in_ch  = RESET_CHANNELS;
      layer_out_ch = RESET_CHANNELS;
      layer_kw     = RESET_KERNEL;
      layer_kh     = RESET_KERNEL;
      in_pos  = 0;
      out_pos = 0;
      row_pos = 0;
      col_pos = 0;
    end else begin
      next_req_valid = req_if.valid;
      next_cfg_valid = cfg_if.valid;
      if (req_if.valid && req_if.ready) begin
        placement_q.push_back(place_word(req_if.weight_in));
        words_sent++;
        next_req_valid = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        write_layer_reg(cfg_if.index, cfg_if.data);
        next_cfg_valid = 1'b0;
      end
      if (placement_q.size() == 0 && !req_if.valid) begin
        if (settle < SETTLE_CYCLES) settle++;
      end else begin
        settle = 0;
      end
      if (!next_req_valid && !next_cfg_valid && word_feed.size() != 0) begin
        if (feed_gap != 0) begin
          feed_gap--;
        end else if (!word_feed[0].is_reg) begin
          req_if.weight_in <= word_feed[0].word;
          next_req_valid = 1'b1;
          void'(word_feed.pop_front());
          feed_gap = pause_len(feed_calm);
        end else if (settle >= SETTLE_CYCLES) begin
          cfg_if.index <= word_feed[0].reg_idx;
          cfg_if.data  <= word_feed[0].reg_data;
          next_cfg_valid = 1'b1;
          void'(word_feed.pop_front());
          feed_gap = pause_len(feed_calm);
        end
      end
      req_if.valid <= next_req_valid;
      cfg_if.valid <= next_cfg_valid;
    end
  end

  // Result monitor with random back-pressure after each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      sink_hold = 0;
      sink_calm = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_if.last_word === 1'b1) tensors_done++;
        if (placement_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result addr %0d word %h last %b",
                                  rsp_if.dest_address, rsp_if.weight_out, rsp_if.last_word));
        end else begin
          want = placement_q.pop_front();
          if (rsp_if.dest_address !== want.dest_address ||
              rsp_if.weight_out !== want.weight_out ||
              rsp_if.last_word !== want.last_word) begin
            flag_mismatch($sformatf(
              "expected addr %0d word %h last %b, got addr %0d word %h last %b",
              want.dest_address, want.weight_out, want.last_word,
              rsp_if.dest_address, rsp_if.weight_out, rsp_if.last_word));
          end
        end
        sink_hold = pause_len(sink_calm);
      end
      if (sink_hold != 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_cnt, placement_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned      random_words;
    int unsigned      tensor_size;
    int unsigned      len;
    int unsigned      split;
    int unsigned      start;
    logic [CFG_W-1:0] phase_val [NUM_REGS];

    rst_ni           = 1'b0;
    random_words     = 0;

    // Reset shape: 32x32 channels with a 3x3 kernel.
    queue_word('0);
    queue_word('1);
    queue_word(16'h5555);
    queue_word(16'hAAAA);
    // Zero registers read as one, so every word is a whole tensor.
    set_layer('0, '0, '0, '0);
    queue_word(16'h8000);
    queue_word(16'h7FFF);
    queue_word(rand_word());
    // Oversized registers saturate; the flipped kernel puts the first words at the highest kernel positions.
    set_layer('1, CFG_W'(MAX_CHANNELS), CFG_W'(15), CFG_W'(MAX_KERNEL));
    repeat (3) queue_word(rand_word());
    // Small tensor of 12 words: a write to an unused index mid-tensor keeps the
    // position, the tensor wraps, and rewriting a register restarts it.
    set_layer(CFG_W'(2), CFG_W'(3), CFG_W'(1), CFG_W'(2));
    repeat (5) queue_word(rand_word());
    queue_reg(IDX_W'(IDX_TOP), CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
    repeat (8) queue_word(rand_word());
    queue_reg(REG_KERNEL_WIDTH, CFG_W'(1));
    repeat (2) queue_word(rand_word());

    while (random_words < WORD_COUNT) begin
      phase_val[REG_IN_CHANNELS]   = pick_channels();
      phase_val[REG_OUT_CHANNELS]  = pick_channels();
      phase_val[REG_KERNEL_WIDTH]  = pick_kernel();
      phase_val[REG_KERNEL_HEIGHT] = pick_kernel();
      start = $urandom_range(0, NUM_REGS - 1);
      for (int k = 0; k < NUM_REGS; k++) begin
        queue_reg(IDX_W'((start + k) % NUM_REGS), phase_val[(start + k) % NUM_REGS]);
      end
      shapes++;
      tensor_size = limit_dim(32'(phase_val[REG_IN_CHANNELS]), MAX_CHANNELS)
                  * limit_dim(32'(phase_val[REG_OUT_CHANNELS]), MAX_CHANNELS)
                  * limit_dim(32'(phase_val[REG_KERNEL_WIDTH][CFG_K_W-1:0]), MAX_KERNEL)
                  * limit_dim(32'(phase_val[REG_KERNEL_HEIGHT][CFG_K_W-1:0]), MAX_KERNEL);
      len = (tensor_size <= 300) ? tensor_size + $urandom_range(0, tensor_size)
                                 : $urandom_range(16, 120);
      split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      for (int n = 0; n < len; n++) begin
        if (split != 0 && n == split) begin
          queue_reg(IDX_W'($urandom_range(FIRST_UNUSED_IDX, IDX_TOP)),
                    CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
        end
        queue_word(rand_word());
      end
      random_words += len;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (word_feed.size() != 0 || req_if.valid || cfg_if.valid || placement_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Reordered %0d weights over %0d layer shapes (%0d register writes, %0d dropped).",
             words_sent, shapes, reg_writes, ignored_writes);
    $display("Observed %0d end-of-tensor flags; %0d mismatching results.",
             tensors_done, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
